// File: rtl/smhs_pkg.sv
// ----------------------------------------------------------------------------
// smhs_pkg
// Shared widths, codes and record types of the stride / feedback queue
// hybrid scheduler.
// ----------------------------------------------------------------------------
package smhs_pkg;

  localparam int PASS_W     = 40;
  localparam int TICK_W     = 16;
  localparam int SHARE_W    = 8;
  localparam int REQ_SHR_W  = 7;
  localparam int SLOT_W     = 6;
  localparam int TOTAL_W    = 13;
  localparam int MASK_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int STRIDE_W   = 7;

  localparam logic [PASS_W-1:0]   PASS_MAX     = '1;
  localparam logic [TICK_W-1:0]   TICK_MAX     = '1;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = '1;
  localparam logic [SHARE_W-1:0]  ADMIT_SHARE  = 8'd10;
  localparam logic [STRIDE_W-1:0] STRIDE_UNITS = 7'd100;

  localparam logic [1:0] LVL_0    = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_NONE = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_JOIN  = 2'd2,
    OP_ADMIT = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NO_GRANT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Q0     = 3'd0,
    REG_Q1     = 3'd1,
    REG_Q2     = 3'd2,
    REG_ALLOT0 = 3'd3,
    REG_ALLOT1 = 3'd4,
    REG_BOOST  = 3'd5,
    REG_GSHARE = 3'd6,
    REG_LIMIT  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [SHARE_W-1:0] share;
    logic [1:0]         parked;
    logic [PASS_W-1:0]  pass;
    logic [TICK_W-1:0]  ticks;
  } slot_ent_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] ticks;
  } q_ent_t;

  localparam slot_ent_t SLOT_ENT_RESET = '{share: '0, parked: LVL_NONE, pass: '0, ticks: '0};

endpackage

// File: rtl/stride_mlfq_hybrid_scheduler_core.sv
// ----------------------------------------------------------------------------
// stride_mlfq_hybrid_scheduler_core
// Stride scheduler with a three-level feedback queue group as one client.
// ----------------------------------------------------------------------------
// Operation: a command scans min(SLOTS,64) slot table entries, reading and
//   updating one entry at a time. A tick takes the same scan, then a walk over
//   the queue entries or the boosted entries, then the bit-serial stride divider.
// Throughput: one request at a time; the next is taken once the result is
//   registered at the output. Reset clears the state machine, the queue
//   pointers and the group state at once; slot table entries read as reset
//   values until written (per-entry valid bits).
module stride_mlfq_hybrid_scheduler_core
  import smhs_pkg::*;
#(
  parameter int SLOTS              = 64,
  parameter int PASS_FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [REQ_SHR_W-1:0]  share_i,
  input  logic [MASK_W-1:0]     runnable_mask_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic                  grant_valid_o,
  output logic [SLOT_W-1:0]     granted_slot_o,
  output logic                  by_queues_o,
  output logic [1:0]            grant_level_o,
  output logic [TOTAL_W-1:0]    total_share_o
);

  localparam int SW     = $clog2(SLOTS);
  localparam int NSCAN  = (SLOTS < MASK_W) ? SLOTS : MASK_W;
  localparam int QDEPTH = 3 * SLOTS;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int CNW    = $clog2(SLOTS + 1);
  localparam int DW     = STRIDE_W + PASS_FRACTION_BITS;
  localparam int DCW    = $clog2(DW);
  localparam logic [DW-1:0] DIVIDEND = DW'(STRIDE_UNITS) << PASS_FRACTION_BITS;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_START  = 16'h0002,
    S_SRD    = 16'h0004,
    S_SEX    = 16'h0008,
    S_SEND   = 16'h0010,
    S_NQRD   = 16'h0020,
    S_NQEX   = 16'h0040,
    S_NSEX   = 16'h0080,
    S_WEND   = 16'h0100,
    S_BRD    = 16'h0200,
    S_BEX    = 16'h0400,
    S_DECIDE = 16'h0800,
    S_GPUSH  = 16'h1000,
    S_DIV    = 16'h2000,
    S_PADD   = 16'h4000,
    S_OUT    = 16'h8000
  } state_e;

  function automatic logic [QAW-1:0] qaddr(input logic [1:0] l, input logic [SW-1:0] p);
    return QAW'(l) * QAW'(SLOTS) + QAW'(p);
  endfunction

  function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
    return (p == SW'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [3:0]  reg_q0_q, reg_q1_q, reg_q2_q;
  logic [9:0]  reg_allot0_q, reg_allot1_q;
  logic [13:0] reg_boost_q;
  logic [6:0]  reg_gshare_q, reg_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q0_q     <= 4'd1;
      reg_q1_q     <= 4'd2;
      reg_q2_q     <= 4'd4;
      reg_allot0_q <= 10'd5;
      reg_allot1_q <= 10'd10;
      reg_boost_q  <= 14'd40;
      reg_gshare_q <= 7'd20;
      reg_limit_q  <= 7'd100;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_Q0:     reg_q0_q     <= cfg_data_i[3:0];
        REG_Q1:     reg_q1_q     <= cfg_data_i[3:0];
        REG_Q2:     reg_q2_q     <= cfg_data_i[3:0];
        REG_ALLOT0: reg_allot0_q <= cfg_data_i[9:0];
        REG_ALLOT1: reg_allot1_q <= cfg_data_i[9:0];
        REG_BOOST:  reg_boost_q  <= cfg_data_i;
        REG_GSHARE: reg_gshare_q <= cfg_data_i[6:0];
        REG_LIMIT:  reg_limit_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // control and scheduler state
  state_e              state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [REQ_SHR_W-1:0] share_q, share_d;
  logic [MASK_W-1:0]   mask_q, mask_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic                have_q, have_d;
  logic [PASS_W-1:0]   best_q, best_d;
  logic [SW-1:0]       pick_q, pick_d;
  logic [SHARE_W-1:0]  pick_share_q, pick_share_d;
  logic [13:0]         total_q, total_d;
  logic [1:0]          lev_q, lev_d;
  logic                boosted_q, boosted_d;
  logic [1:0]          qsel_q, qsel_d;
  logic [SLOT_W-1:0]   fs_q, fs_d;
  logic [TICK_W-1:0]   ft_q, ft_d;
  logic                grp_q, grp_d;
  logic [1:0]          gp_lev_q, gp_lev_d;
  logic [TICK_W-1:0]   gp_ticks_q, gp_ticks_d;
  logic [DCW-1:0]      div_cnt_q, div_cnt_d;
  logic [DW-1:0]       dsh_q, dsh_d;
  logic [DW-1:0]       quo_q, quo_d;
  logic [SHARE_W-1:0]  rem_q, rem_d;
  logic [SHARE_W-1:0]  divr_q, divr_d;
  logic [PASS_W-1:0]   pbase_q, pbase_d;
  status_e             res_status_q, res_status_d;
  logic                res_gv_q, res_gv_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                res_bq_q, res_bq_d;
  logic [1:0]          res_lvl_q, res_lvl_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic                out_gv_q, out_gv_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic                out_bq_q, out_bq_d;
  logic [1:0]          out_lvl_q, out_lvl_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;
  logic [PASS_W-1:0]   gpass_q, gpass_d;
  logic [6:0]          gas_q, gas_d;
  logic                mv_q, mv_d;
  logic [SLOT_W-1:0]   cm_q, cm_d;
  logic [1:0]          cl_q, cl_d;
  logic [3:0]          rq_q, rq_d;
  logic [TICK_W-1:0]   cmt_q, cmt_d;
  logic [TOTAL_W-1:0]  stotal_q, stotal_d;
  logic [SW-1:0]       head_q [3], head_d [3];
  logic [SW-1:0]       tail_q [3], tail_d [3];
  logic [CNW-1:0]      cnt_q [3], cnt_d [3];

  // slot table
  slot_ent_t       sm_mem [SLOTS];
  logic [SLOTS-1:0] sm_vld_q;
  slot_ent_t       sm_rdata_q, sm_wdata;
  logic            sm_rvld_q, sm_we;
  logic [SW-1:0]   sm_raddr, sm_waddr;

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      sm_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata_q <= sm_mem[sm_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_vld_q  <= '0;
      sm_rvld_q <= 1'b0;
    end else begin
      sm_rvld_q <= sm_vld_q[sm_raddr];
      if (sm_we) begin
        sm_vld_q[sm_waddr] <= 1'b1;
      end
    end
  end

  // level queues
  q_ent_t          qm_mem [QDEPTH];
  q_ent_t          qm_rdata_q, qm_wdata;
  logic            qm_we;
  logic [QAW-1:0]  qm_raddr, qm_waddr;

  always_ff @(posedge clk_i) begin
    if (qm_we) begin
      qm_mem[qm_waddr] <= qm_wdata;
    end
    qm_rdata_q <= qm_mem[qm_raddr];
  end

  // queue pointer control
  logic                push_en, pop_en;
  logic [1:0]          push_lev, pop_lev, rd_lev;
  logic [SLOT_W-1:0]   push_slot;
  logic [TICK_W-1:0]   push_ticks;
  logic [2:0]          push_ok;
  logic [CNW-1:0]      lev_cnt;

  always_comb begin
    qm_we    = 1'b0;
    qm_waddr = '0;
    qm_wdata = '{slot: push_slot, ticks: push_ticks};
    qm_raddr = '0;
    lev_cnt  = '0;
    for (int l = 0; l < 3; l++) begin
      push_ok[l] = push_en && (push_lev == 2'(l)) && (cnt_q[l] != CNW'(SLOTS));
      head_d[l]  = (pop_en && pop_lev == 2'(l)) ? ptr_inc(head_q[l]) : head_q[l];
      tail_d[l]  = push_ok[l] ? ptr_inc(tail_q[l]) : tail_q[l];
      cnt_d[l]   = cnt_q[l] + CNW'(push_ok[l]) - CNW'(pop_en && pop_lev == 2'(l));
      if (push_ok[l]) begin
        qm_we    = 1'b1;
        qm_waddr = qaddr(2'(l), tail_q[l]);
      end
      if (rd_lev == 2'(l)) begin
        qm_raddr = qaddr(2'(l), head_q[l]);
      end
      if (lev_q == 2'(l)) begin
        lev_cnt = cnt_q[l];
      end
    end
  end

  // effective entry
  slot_ent_t ent;
  logic      scan_run, fs_run, cm_run;

  always_comb begin
    ent = sm_rvld_q ? sm_rdata_q : SLOT_ENT_RESET;
    if (state_q == S_SEX && op_q == OP_ADMIT && SLOT_W'(idx_q) == slot_q) begin
      ent.share  = ADMIT_SHARE;
      ent.parked = LVL_NONE;
    end
  end

  assign scan_run = mask_q[SLOT_W'(idx_q)];
  assign fs_run   = mask_q[fs_q];
  assign cm_run   = mask_q[cm_q];

  logic [3:0]          sel_quant;
  logic [9:0]          sel_allot;
  logic [TICK_W:0]     t_sum;
  logic [TICK_W-1:0]   t_new;
  logic [PASS_W-1:0]   m_pass;
  logic [14:0]         tot_sum;
  logic [13:0]         chk_sum;
  logic [SHARE_W:0]    trial;
  logic                trial_ge;
  logic [PASS_W:0]     p_sum;
  logic                grp_win;

  always_comb begin
    case (qsel_q)
      LVL_0:   sel_quant = reg_q0_q;
      LVL_1:   sel_quant = reg_q1_q;
      default: sel_quant = reg_q2_q;
    endcase
    sel_allot = (qsel_q == LVL_0) ? reg_allot0_q : reg_allot1_q;
    t_sum     = {1'b0, ft_q} + (TICK_W+1)'(sel_quant);
    t_new     = t_sum[TICK_W] ? TICK_MAX : t_sum[TICK_W-1:0];
    m_pass    = have_q ? best_q : '0;
    if (gas_q != '0 && (!have_q || gpass_q < best_q)) begin
      m_pass = gpass_q;
    end
    tot_sum   = {1'b0, total_q} + 15'(gas_q);
    trial     = {rem_q, dsh_q[DW-1]};
    trial_ge  = trial >= {1'b0, divr_q};
    p_sum     = {1'b0, pbase_q} + (PASS_W+1)'(quo_q);
    grp_win   = (qsel_q != LVL_NONE) && (!have_q || gpass_q < best_q);
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    slot_d       = slot_q;
    share_d      = share_q;
    mask_d       = mask_q;
    idx_d        = idx_q;
    have_d       = have_q;
    best_d       = best_q;
    pick_d       = pick_q;
    pick_share_d = pick_share_q;
    total_d      = total_q;
    lev_d        = lev_q;
    boosted_d    = boosted_q;
    qsel_d       = qsel_q;
    fs_d         = fs_q;
    ft_d         = ft_q;
    grp_d        = grp_q;
    gp_lev_d     = gp_lev_q;
    gp_ticks_d   = gp_ticks_q;
    div_cnt_d    = div_cnt_q;
    dsh_d        = dsh_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    divr_d       = divr_q;
    pbase_d      = pbase_q;
    res_status_d = res_status_q;
    res_gv_d     = res_gv_q;
    res_slot_d   = res_slot_q;
    res_bq_d     = res_bq_q;
    res_lvl_d    = res_lvl_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_gv_d     = out_gv_q;
    out_slot_d   = out_slot_q;
    out_bq_d     = out_bq_q;
    out_lvl_d    = out_lvl_q;
    out_total_d  = out_total_q;
    gpass_d      = gpass_q;
    gas_d        = gas_q;
    mv_d         = mv_q;
    cm_d         = cm_q;
    cl_d         = cl_q;
    rq_d         = rq_q;
    cmt_d        = cmt_q;
    stotal_d     = stotal_q;
    sm_we        = 1'b0;
    sm_waddr     = idx_q;
    sm_wdata     = ent;
    sm_raddr     = idx_q;
    push_en      = 1'b0;
    push_lev     = LVL_0;
    push_slot    = '0;
    push_ticks   = '0;
    pop_en       = 1'b0;
    pop_lev      = LVL_0;
    rd_lev       = (lev_q == LVL_NONE) ? LVL_0 : lev_q;
    chk_sum      = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          slot_d  = slot_i;
          share_d = share_i;
          mask_d  = runnable_mask_i;
          state_d = S_START;
        end
      end

      S_START: begin
        idx_d        = '0;
        have_d       = 1'b0;
        best_d       = '0;
        pick_d       = '0;
        pick_share_d = '0;
        total_d      = '0;
        res_status_d = ST_DONE;
        res_gv_d     = 1'b0;
        res_slot_d   = '0;
        res_bq_d     = 1'b0;
        res_lvl_d    = LVL_NONE;
        state_d      = S_SRD;
        if (op_q != OP_TICK) begin
          if (32'(slot_q) >= SLOTS) begin
            state_d = S_OUT;
          end else if (op_q == OP_SET) begin
            chk_sum = {1'b0, stotal_q} + 14'(share_q);
            if (chk_sum > 14'(reg_limit_q)) begin
              res_status_d = ST_REJECT;
              state_d      = S_OUT;
            end
          end else if (op_q == OP_JOIN) begin
            chk_sum = {1'b0, stotal_q} + 14'(reg_gshare_q);
            if (gas_q == '0 && chk_sum > 14'(reg_limit_q)) begin
              res_status_d = ST_REJECT;
              state_d      = S_OUT;
            end
          end
        end
      end

      S_SRD: begin
        state_d = S_SEX;
      end

      S_SEX: begin
        if (scan_run && ent.parked != LVL_NONE) begin
          if (op_q == OP_TICK) begin
            push_en    = 1'b1;
            push_lev   = ent.parked;
            push_slot  = SLOT_W'(idx_q);
            push_ticks = ent.ticks;
            sm_we      = 1'b1;
            sm_wdata   = '{share: '0, parked: LVL_NONE, pass: ent.pass, ticks: '0};
          end
        end else if (scan_run) begin
          total_d = total_q + 14'(ent.share);
          if (ent.share != '0 && (!have_q || ent.pass < best_q)) begin
            have_d       = 1'b1;
            best_d       = ent.pass;
            pick_d       = idx_q;
            pick_share_d = ent.share;
          end
        end
        if (idx_q == SW'(NSCAN - 1)) begin
          state_d = S_SEND;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SRD;
        end
      end

      S_SEND: begin
        sm_waddr = SW'(slot_q);
        if (op_q == OP_TICK) begin
          stotal_d  = (tot_sum > 15'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(tot_sum);
          qsel_d    = LVL_NONE;
          lev_d     = LVL_0;
          boosted_d = 1'b0;
          state_d   = (gas_q != '0) ? S_NQRD : S_DECIDE;
        end else begin
          sm_we   = 1'b1;
          state_d = S_OUT;
          case (op_q)
            OP_ADMIT: begin
              chk_sum  = {1'b0, stotal_q} + 14'(ADMIT_SHARE);
              stotal_d = (chk_sum > 14'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(chk_sum);
              sm_wdata = '{share: ADMIT_SHARE, parked: LVL_NONE, pass: m_pass, ticks: '0};
            end
            OP_SET: begin
              sm_wdata = '{share: SHARE_W'(share_q), parked: LVL_NONE, pass: m_pass,
                           ticks: '0};
            end
            default: begin
              sm_wdata  = SLOT_ENT_RESET;
              gas_d     = reg_gshare_q;
              gpass_d   = m_pass;
              push_en   = 1'b1;
              push_lev  = LVL_0;
              push_slot = slot_q;
            end
          endcase
        end
      end

      S_NQRD: begin
        if (lev_q == LVL_NONE) begin
          state_d = S_WEND;
        end else if (lev_cnt == '0) begin
          lev_d = lev_q + 1'b1;
        end else begin
          state_d = S_NQEX;
        end
      end

      S_NQEX: begin
        fs_d     = qm_rdata_q.slot;
        ft_d     = qm_rdata_q.ticks;
        sm_raddr = SW'(qm_rdata_q.slot);
        state_d  = S_NSEX;
      end

      S_NSEX: begin
        sm_waddr = SW'(fs_q);
        if (ent.parked == LVL_NONE && ent.share != '0) begin
          pop_en  = 1'b1;
          pop_lev = lev_q;
          state_d = S_NQRD;
        end else if (!fs_run) begin
          sm_we    = 1'b1;
          sm_wdata = '{share: '0, parked: lev_q, pass: ent.pass, ticks: ft_q};
          pop_en   = 1'b1;
          pop_lev  = lev_q;
          state_d  = S_NQRD;
        end else begin
          qsel_d  = lev_q;
          state_d = S_WEND;
        end
      end

      S_WEND: begin
        state_d = S_DECIDE;
        if (qsel_q == LVL_NONE) begin
          if (!boosted_q) begin
            stotal_d = (stotal_q >= TOTAL_W'(gas_q)) ? stotal_q - TOTAL_W'(gas_q) : '0;
            gas_d    = '0;
          end
        end else if (!boosted_q && cl_q == LVL_2 && cmt_q > TICK_W'(reg_boost_q)) begin
          boosted_d = 1'b1;
          state_d   = S_BRD;
        end
      end

      S_BRD: begin
        rd_lev = LVL_2;
        if (cnt_q[2] == '0) begin
          lev_d   = LVL_0;
          qsel_d  = LVL_NONE;
          state_d = S_NQRD;
        end else begin
          state_d = S_BEX;
        end
      end

      S_BEX: begin
        pop_en    = 1'b1;
        pop_lev   = LVL_2;
        push_en   = 1'b1;
        push_lev  = LVL_0;
        push_slot = qm_rdata_q.slot;
        state_d   = S_BRD;
      end

      S_DECIDE: begin
        grp_d     = grp_win;
        dsh_d     = DIVIDEND;
        quo_d     = '0;
        rem_d     = '0;
        div_cnt_d = '0;
        if (grp_win) begin
          divr_d       = SHARE_W'(gas_q);
          pbase_d      = gpass_q;
          res_status_d = ST_DONE;
          res_gv_d     = 1'b1;
          res_bq_d     = 1'b1;
          res_slot_d   = cm_q;
          res_lvl_d    = cl_q;
          state_d      = S_DIV;
          if (rq_q == '0 || !mv_q || !cm_run) begin
            pop_en     = 1'b1;
            pop_lev    = qsel_q;
            mv_d       = 1'b1;
            cm_d       = fs_q;
            cl_d       = qsel_q;
            cmt_d      = t_new;
            rq_d       = (sel_quant != '0) ? sel_quant - 1'b1 : '0;
            res_slot_d = fs_q;
            res_lvl_d  = qsel_q;
            if (qsel_q != LVL_2 && t_new >= TICK_W'(sel_allot)) begin
              gp_lev_d   = qsel_q + 1'b1;
              gp_ticks_d = '0;
            end else begin
              gp_lev_d   = qsel_q;
              gp_ticks_d = t_new;
            end
            state_d = S_GPUSH;
          end else if (rq_q != '0) begin
            rq_d = rq_q - 1'b1;
          end
        end else if (!have_q) begin
          res_status_d = ST_NO_GRANT;
          res_gv_d     = 1'b0;
          res_slot_d   = '0;
          res_bq_d     = 1'b0;
          res_lvl_d    = LVL_NONE;
          state_d      = S_OUT;
        end else begin
          divr_d       = pick_share_q;
          pbase_d      = best_q;
          res_status_d = ST_DONE;
          res_gv_d     = 1'b1;
          res_slot_d   = SLOT_W'(pick_q);
          res_bq_d     = 1'b0;
          res_lvl_d    = LVL_NONE;
          state_d      = S_DIV;
        end
      end

      S_GPUSH: begin
        push_en    = 1'b1;
        push_lev   = gp_lev_q;
        push_slot  = cm_q;
        push_ticks = gp_ticks_q;
        state_d    = S_DIV;
      end

      S_DIV: begin
        rem_d     = trial_ge ? SHARE_W'(trial - {1'b0, divr_q}) : SHARE_W'(trial);
        quo_d     = {quo_q[DW-2:0], trial_ge};
        dsh_d     = dsh_q << 1;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DCW'(DW - 1)) begin
          state_d = S_PADD;
        end
      end

      S_PADD: begin
        if (grp_q) begin
          gpass_d = p_sum[PASS_W] ? PASS_MAX : p_sum[PASS_W-1:0];
        end else begin
          sm_we    = 1'b1;
          sm_waddr = pick_q;
          sm_wdata = '{share: pick_share_q, parked: LVL_NONE,
                       pass: p_sum[PASS_W] ? PASS_MAX : p_sum[PASS_W-1:0], ticks: '0};
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_gv_d     = res_gv_q;
          out_slot_d   = res_slot_q;
          out_bq_d     = res_bq_q;
          out_lvl_d    = res_lvl_q;
          out_total_d  = stotal_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      gpass_q     <= '0;
      gas_q       <= '0;
      mv_q        <= 1'b0;
      cm_q        <= '0;
      cl_q        <= LVL_0;
      rq_q        <= '0;
      cmt_q       <= '0;
      stotal_q    <= '0;
      for (int l = 0; l < 3; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      gpass_q     <= gpass_d;
      gas_q       <= gas_d;
      mv_q        <= mv_d;
      cm_q        <= cm_d;
      cl_q        <= cl_d;
      rq_q        <= rq_d;
      cmt_q       <= cmt_d;
      stotal_q    <= stotal_d;
      for (int l = 0; l < 3; l++) begin
        head_q[l] <= head_d[l];
        tail_q[l] <= tail_d[l];
        cnt_q[l]  <= cnt_d[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    slot_q       <= slot_d;
    share_q      <= share_d;
    mask_q       <= mask_d;
    idx_q        <= idx_d;
    have_q       <= have_d;
    best_q       <= best_d;
    pick_q       <= pick_d;
    pick_share_q <= pick_share_d;
    total_q      <= total_d;
    lev_q        <= lev_d;
    boosted_q    <= boosted_d;
    qsel_q       <= qsel_d;
    fs_q         <= fs_d;
    ft_q         <= ft_d;
    grp_q        <= grp_d;
    gp_lev_q     <= gp_lev_d;
    gp_ticks_q   <= gp_ticks_d;
    div_cnt_q    <= div_cnt_d;
    dsh_q        <= dsh_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    divr_q       <= divr_d;
    pbase_q      <= pbase_d;
    res_status_q <= res_status_d;
    res_gv_q     <= res_gv_d;
    res_slot_q   <= res_slot_d;
    res_bq_q     <= res_bq_d;
    res_lvl_q    <= res_lvl_d;
    out_status_q <= out_status_d;
    out_gv_q     <= out_gv_d;
    out_slot_q   <= out_slot_d;
    out_bq_q     <= out_bq_d;
    out_lvl_q    <= out_lvl_d;
    out_total_q  <= out_total_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign grant_valid_o  = out_gv_q;
  assign granted_slot_o = out_slot_q;
  assign by_queues_o    = out_bq_q;
  assign grant_level_o  = out_lvl_q;
  assign total_share_o  = out_total_q;

  a_queue_grant_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && by_queues_o |-> grant_valid_o && grant_level_o != LVL_NONE)
    else $error("queue grant without a level");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CNW'(SLOTS) && cnt_q[1] <= CNW'(SLOTS) && cnt_q[2] <= CNW'(SLOTS))
    else $error("queue count beyond depth");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_member_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q |-> cl_q != LVL_NONE)
    else $error("current member without a level");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stride / feedback queue hybrid scheduler.
// A short table of directed requests is followed by random request streams
// over several register settings and idle patterns. Each accepted request is
// run through a local scheduler model; outputs are compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import smhs_pkg::*;

  localparam int       NSLOT      = 64;
  localparam longint   CYCLE_CAP  = 40_000_000;
  localparam int       DRAIN_WAIT = 1200;

  typedef struct packed {
    status_e           status;
    logic              grant_valid;
    logic [SLOT_W-1:0] granted_slot;
    logic              by_queues;
    logic [1:0]        grant_level;
    logic [TOTAL_W-1:0] total_share;
  } sched_out_t;

  typedef struct {
    opcode_e     op;
    int          slot;
    int          shr;
    logic [63:0] mask;
    bit          typed;
    sched_out_t  res;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            opcode_i = '0;
  logic [SLOT_W-1:0]     slot_i = '0;
  logic [REQ_SHR_W-1:0]  share_i = '0;
  logic [MASK_W-1:0]     runnable_mask_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic                  grant_valid_o;
  logic [SLOT_W-1:0]     granted_slot_o;
  logic                  by_queues_o;
  logic [1:0]            grant_level_o;
  logic [TOTAL_W-1:0]    total_share_o;

  stride_mlfq_hybrid_scheduler_core dut (.*);

  always #5 clk_i = ~clk_i;

  // scheduler model state
  int              cfg_val [8];
  int              m_share [NSLOT];
  int              m_park  [NSLOT];
  longint unsigned m_pass  [NSLOT];
  int              m_ptick [NSLOT];
  int              q_slot  [3][NSLOT];
  int              q_tick  [3][NSLOT];
  int              q_head [3], q_tail [3], q_cnt [3];
  longint unsigned grp_pass;
  int              grp_share, cur_member, cur_level, rem_quantum, cur_ticks, share_sum;
  bit              member_ok;

  sched_out_t      pending_results [$];
  int              errors = 0;
  int              n_checked = 0, n_grants = 0, n_queue_grants = 0, n_rejects = 0;
  longint          cycles = 0;
  int              idle_pct = 0, stall_pct = 0;

  const int reg_width [8] = '{4, 4, 4, 10, 10, 14, 7, 7};
  const int reg_reset [8] = '{1, 2, 4, 5, 10, 40, 20, 100};

  function automatic void model_reset();
    for (int r = 0; r < 8; r++) cfg_val[r] = reg_reset[r];
    for (int i = 0; i < NSLOT; i++) begin
      m_share[i] = 0; m_park[i] = LVL_NONE; m_pass[i] = 0; m_ptick[i] = 0;
    end
    for (int l = 0; l < 3; l++) begin
      q_head[l] = 0; q_tail[l] = 0; q_cnt[l] = 0;
    end
    grp_pass = 0; grp_share = 0; member_ok = 0; cur_member = 0; cur_level = 0;
    rem_quantum = 0; cur_ticks = 0; share_sum = 0;
  endfunction

  function automatic longint unsigned advance_pass(longint unsigned p, int s);
    longint unsigned r;
    r = p + (64'd100 << 16) / s;
    return (r > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : r;
  endfunction

  function automatic longint unsigned lowest_pass(logic [63:0] mask);
    bit              found = 0;
    longint unsigned m = 0;
    for (int i = 0; i < NSLOT; i++)
      if (mask[i] && m_park[i] == LVL_NONE && m_share[i] > 0 && (!found || m_pass[i] < m)) begin
        m = m_pass[i]; found = 1;
      end
    if (grp_share > 0 && (!found || grp_pass < m)) begin
      m = grp_pass; found = 1;
    end
    return found ? m : 0;
  endfunction

  function automatic void enqueue(int lev, int s, int t);
    if (q_cnt[lev] >= NSLOT) return;
    q_slot[lev][q_tail[lev]] = s;
    q_tick[lev][q_tail[lev]] = t;
    q_tail[lev] = (q_tail[lev] + 1) % NSLOT;
    q_cnt[lev]++;
  endfunction

  function automatic void dequeue(int lev);
    q_head[lev] = (q_head[lev] + 1) % NSLOT;
    q_cnt[lev]--;
  endfunction

  function automatic int front_level(logic [63:0] mask);
    int s;
    for (int lev = 0; lev < 3; lev++) begin
      while (q_cnt[lev] > 0) begin
        s = q_slot[lev][q_head[lev]];
        if (m_park[s] == LVL_NONE && m_share[s] > 0) begin
          dequeue(lev);
        end else if (!mask[s]) begin
          m_park[s] = lev; m_share[s] = 0; m_ptick[s] = q_tick[lev][q_head[lev]];
          dequeue(lev);
        end else begin
          return lev;
        end
      end
    end
    return LVL_NONE;
  endfunction

  function automatic sched_out_t make_out(status_e st, bit gv, int gs, bit bq, int gl);
    sched_out_t o;
    o.status = st; o.grant_valid = gv; o.granted_slot = gs; o.by_queues = bq;
    o.grant_level = gl; o.total_share = share_sum;
    return o;
  endfunction

  function automatic sched_out_t predict_schedule(opcode_e op, int slot, int shr,
                                                  logic [63:0] mask);
    status_e         st = ST_DONE;
    longint unsigned m, best = 0;
    int              total = 0, q = LVL_NONE, pick = 0, s, t, quantum;
    bit              have = 0;
    if (op != OP_TICK) begin
      if (op == OP_ADMIT) begin
        m_share[slot] = ADMIT_SHARE; m_park[slot] = LVL_NONE; m_ptick[slot] = 0;
        share_sum = (share_sum + 10 > 8191) ? 8191 : share_sum + 10;
        m_pass[slot] = lowest_pass(mask);
      end else if (op == OP_SET) begin
        if (share_sum + shr > cfg_val[REG_LIMIT]) begin
          st = ST_REJECT;
        end else begin
          m = lowest_pass(mask);
          m_share[slot] = shr; m_park[slot] = LVL_NONE; m_pass[slot] = m;
        end
      end else begin
        m = lowest_pass(mask);
        if (grp_share == 0 && share_sum + cfg_val[REG_GSHARE] > cfg_val[REG_LIMIT]) begin
          st = ST_REJECT;
        end else begin
          m_share[slot] = 0; m_park[slot] = LVL_NONE; m_pass[slot] = 0;
          grp_share = cfg_val[REG_GSHARE]; grp_pass = m;
          enqueue(LVL_0, slot, 0);
        end
      end
      return make_out(st, 0, 0, 0, LVL_NONE);
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (!mask[i]) continue;
      if (m_park[i] != LVL_NONE) begin
        enqueue(m_park[i], i, m_ptick[i]);
        m_ptick[i] = 0; m_park[i] = LVL_NONE; m_share[i] = 0;
        continue;
      end
      total += m_share[i];
      if (m_share[i] > 0 && (!have || m_pass[i] < best)) begin
        have = 1; pick = i; best = m_pass[i];
      end
    end
    total += grp_share;
    share_sum = (total > 8191) ? 8191 : total;
    if (grp_share > 0) begin
      q = front_level(mask);
      if (q == LVL_NONE) begin
        share_sum = (share_sum >= grp_share) ? share_sum - grp_share : 0;
        grp_share = 0;
      end else if (cur_level == LVL_2 && cur_ticks > cfg_val[REG_BOOST]) begin
        while (q_cnt[2] > 0) begin
          s = q_slot[2][q_head[2]];
          dequeue(2);
          enqueue(LVL_0, s, 0);
        end
        q = front_level(mask);
      end
    end
    if (q != LVL_NONE && grp_share > 0 && (!have || grp_pass < best)) begin
      if (rem_quantum == 0 || !member_ok || !mask[cur_member]) begin
        s = q_slot[q][q_head[q]];
        t = q_tick[q][q_head[q]];
        quantum = cfg_val[q];
        dequeue(q);
        member_ok = 1; cur_member = s; rem_quantum = quantum; cur_level = q;
        t = (t + quantum > 65535) ? 65535 : t + quantum;
        cur_ticks = t;
        if (q < 2 && t >= cfg_val[REG_ALLOT0 + q]) enqueue(q + 1, s, 0);
        else enqueue(q, s, t);
      end
      if (rem_quantum > 0) rem_quantum--;
      grp_pass = advance_pass(grp_pass, grp_share);
      return make_out(ST_DONE, 1, cur_member, 1, cur_level);
    end
    if (!have) return make_out(ST_NO_GRANT, 0, 0, 0, LVL_NONE);
    m_pass[pick] = advance_pass(m_pass[pick], m_share[pick]);
    return make_out(ST_DONE, 1, pick, 0, LVL_NONE);
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    sched_out_t exp_r, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_e'(status_o); got.grant_valid = grant_valid_o;
      got.granted_slot = granted_slot_o; got.by_queues = by_queues_o;
      got.grant_level = grant_level_o; got.total_share = total_share_o;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (got.grant_valid) n_grants++;
        if (got.by_queues) n_queue_grants++;
        if (got.status == ST_REJECT) n_rejects++;
        if (got.status != exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status); errors++;
        end
        if (got.grant_valid != exp_r.grant_valid) begin
          $display("%0t: grant_valid exp %0d got %0d", $time, exp_r.grant_valid,
                   got.grant_valid); errors++;
        end
        if (got.granted_slot != exp_r.granted_slot) begin
          $display("%0t: granted_slot exp %0d got %0d", $time, exp_r.granted_slot,
                   got.granted_slot); errors++;
        end
        if (got.by_queues != exp_r.by_queues) begin
          $display("%0t: by_queues exp %0d got %0d", $time, exp_r.by_queues,
                   got.by_queues); errors++;
        end
        if (got.grant_level != exp_r.grant_level) begin
          $display("%0t: grant_level exp %0d got %0d", $time, exp_r.grant_level,
                   got.grant_level); errors++;
        end
        if (got.total_share != exp_r.total_share) begin
          $display("%0t: total_share exp %0d got %0d", $time, exp_r.total_share,
                   got.total_share); errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e r, int v);
    cfg_we_i <= 1'b1; cfg_idx_i <= r; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_val[r] = v & ((1 << reg_width[r]) - 1);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // typed: push the hand-written expectation, model still tracks state
  task automatic issue(opcode_e op, int slot, int shr, logic [63:0] mask,
                       bit typed = 0, sched_out_t typed_res = '0);
    sched_out_t r;
    in_valid_i <= 1'b1; opcode_i <= op; slot_i <= slot; share_i <= shr;
    runnable_mask_i <= mask;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = predict_schedule(op, slot, shr, mask);
    pending_results.push_back(typed ? typed_res : r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(5))
      0: return '1;
      1: return '0;
      2: return {$urandom, $urandom};
      3: return {$urandom, $urandom} | {$urandom, $urandom};
      4: return {$urandom, $urandom} & {$urandom, $urandom};
      default: return ~(64'd1 << $urandom_range(63));
    endcase
  endfunction

  task automatic random_requests(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 58) issue(OP_TICK, 0, 0, rand_mask());
      else if (k < 72) issue(OP_JOIN, $urandom_range(63), $urandom_range(127), rand_mask());
      else if (k < 82) issue(OP_ADMIT, $urandom_range(63), $urandom_range(127), rand_mask());
      else if (k < 97) issue(OP_SET, $urandom_range(63),
                             ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(20),
                             rand_mask());
      else issue(OP_TICK, 0, $urandom_range(127), '0);
    end
  endtask

  initial begin
    dir_row_t rows [$];
    dir_row_t d;
    int       phase_idle [4] = '{0, 65, 0, 33};
    int       phase_stall[4] = '{0, 0, 65, 33};

    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; typed rows hold values readable straight from reset state
    d.typed = 1;
    d.op = OP_TICK;  d.slot = 0;  d.shr = 0;   d.mask = '0;
    d.res = '{ST_NO_GRANT, 0, 0, 0, LVL_NONE, 0};  rows.push_back(d);
    d.op = OP_SET;   d.slot = 5;  d.shr = 127; d.mask = '0;
    d.res = '{ST_REJECT, 0, 0, 0, LVL_NONE, 0};    rows.push_back(d);
    d.op = OP_ADMIT; d.slot = 0;  d.shr = 0;   d.mask = '1;
    d.res = '{ST_DONE, 0, 0, 0, LVL_NONE, 10};     rows.push_back(d);
    d.op = OP_SET;   d.slot = 1;  d.shr = 91;  d.mask = '1;
    d.res = '{ST_REJECT, 0, 0, 0, LVL_NONE, 10};   rows.push_back(d);
    d.op = OP_JOIN;  d.slot = 63; d.shr = 0;   d.mask = '1;
    d.res = '{ST_DONE, 0, 0, 0, LVL_NONE, 10};     rows.push_back(d);
    d.typed = 0;
    d.op = OP_SET;   d.slot = 1;  d.shr = 0;   d.mask = '1;                 rows.push_back(d);
    d.op = OP_SET;   d.slot = 2;  d.shr = 90;  d.mask = 64'h5555_5555_5555_5555; rows.push_back(d);
    d.op = OP_TICK;  d.slot = 0;  d.shr = 0;   d.mask = '1;                 rows.push_back(d);
    d.op = OP_JOIN;  d.slot = 0;  d.mask = 64'hAAAA_AAAA_AAAA_AAAA;         rows.push_back(d);
    d.op = OP_TICK;  d.mask = 64'h8000_0000_0000_0000;                      rows.push_back(d);
    d.op = OP_TICK;  d.mask = 64'h0000_0000_0000_0001;                      rows.push_back(d);
    d.op = OP_TICK;  d.mask = '0;                                           rows.push_back(d);
    d.op = OP_TICK;  d.mask = '1;                                           rows.push_back(d);
    d.op = OP_ADMIT; d.slot = 63; d.mask = '1;                              rows.push_back(d);
    d.op = OP_TICK;  d.slot = 0;  d.mask = 64'hAAAA_AAAA_AAAA_AAAA;         rows.push_back(d);
    d.op = OP_JOIN;  d.slot = 7;  d.mask = '1;                              rows.push_back(d);
    for (int i = 0; i < 8; i++) begin
      d.op = OP_TICK; d.slot = 0; d.mask = (i % 3 == 0) ? 64'h8000_0000_0000_0081 : '1;
      rows.push_back(d);
    end
    foreach (rows[i]) issue(rows[i].op, rows[i].slot, rows[i].shr, rows[i].mask,
                            rows[i].typed, rows[i].res);
    in_valid_i <= 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      idle_pct  = phase_idle[p % 4];
      stall_pct = phase_stall[p % 4];
      if (p == 1) begin
        write_reg(REG_Q0, 1); write_reg(REG_Q1, 1); write_reg(REG_Q2, 1);
        write_reg(REG_ALLOT0, 1); write_reg(REG_ALLOT1, 1); write_reg(REG_BOOST, 0);
        write_reg(REG_GSHARE, 1); write_reg(REG_LIMIT, 100);
      end else if (p == 2) begin
        write_reg(REG_Q0, 15); write_reg(REG_Q1, 15); write_reg(REG_Q2, 15);
        write_reg(REG_ALLOT0, 1000); write_reg(REG_ALLOT1, 1000); write_reg(REG_BOOST, 10000);
        write_reg(REG_GSHARE, 100); write_reg(REG_LIMIT, 1);
      end else if (p > 2) begin
        write_reg(REG_Q0, $urandom_range(15)); write_reg(REG_Q1, $urandom_range(1, 15));
        write_reg(REG_Q2, $urandom_range(1, 15));
        write_reg(REG_ALLOT0, $urandom_range(1, 40)); write_reg(REG_ALLOT1, $urandom_range(1, 60));
        write_reg(REG_BOOST, (p == 5) ? 16383 : $urandom_range(0, 80));
        write_reg(REG_GSHARE, $urandom_range(1, 100)); write_reg(REG_LIMIT, $urandom_range(1, 127));
      end
      random_requests(140);
      if (p == 3) begin
        in_valid_i <= 1'b0;
        drain();
      end
      random_requests(140);
      in_valid_i <= 1'b0;
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Covered %0d requests: %0d grants (%0d from the queues), %0d rejects,",
             n_checked, n_grants, n_queue_grants, n_rejects);
    $display("over six register settings and four idle/stall patterns.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/smhs_pkg.sv
rtl/stride_mlfq_hybrid_scheduler_core.sv
tb/tb_top.sv
